>>> hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the i2c master bit sequencer
// Beat structs for the tick and result channels, command codes, register map.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // command codes carried in the action field
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_WACK  = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  // bits in one bus byte, and the bit index counter width
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_IDX_W     = 4;

  // register indexes on the configuration port
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  // register reset values
  localparam logic [15:0] HALF_PERIOD_RST = 16'd200;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd255;

  // one tick beat
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_sample;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } out_beat_t;

  // configuration register values handed to the sequencer core
  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [7:0]  ack_timeout_ticks;
  } cfg_regs_t;

endpackage

>>> hw/rtl/i2cm_seq_core.sv
// ----------------------------------------------------------------------------
// i2cm_seq_core: bus phase sequencer of the i2c master
// Advances the line state machine by one tick per enabled cycle and
// registers the resulting line levels and status as one result beat.
// ----------------------------------------------------------------------------
module i2cm_seq_core
  import i2cm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_beat_t  tick,
  input  cfg_regs_t cfg,
  output out_beat_t res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_S0, PH_S1, PH_P0, PH_P1, PH_WLO, PH_WHI,
    PH_A0, PH_A1, PH_A2, PH_RLO, PH_RHI, PH_KLO, PH_KHI
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0]  count_r, count_nxt;
  logic [BIT_IDX_W-1:0]    bit_r, bit_nxt;
  logic [7:0]              tx_r, tx_nxt;
  logic [7:0]              rx_r, rx_nxt;
  logic [7:0]              poll_r, poll_nxt;
  logic                    pend_r, pend_nxt;
  logic                    scl_r, scl_nxt;
  logic                    sda_r, sda_nxt;
  logic                    drv_r, drv_nxt;
  logic                    miss_r, miss_nxt;
  logic                    done_nxt;
  out_beat_t               res_r;

  logic [TIMER_WIDTH-1:0]  hp;
  logic [TIMER_WIDTH:0]    count_inc;
  logic                    hold_half;
  logic [8:0]              poll_inc;
  logic [BIT_IDX_W-1:0]    bit_inc;

  // half period limit and counter compares
  assign hp        = TIMER_WIDTH'(cfg.half_period_ticks);
  assign count_inc = {1'b0, count_r} + 1'b1;
  assign hold_half = count_inc < {1'b0, hp};
  assign poll_inc  = {1'b0, poll_r} + 1'b1;
  assign bit_inc   = bit_r + 1'b1;

  // next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    bit_nxt   = bit_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    poll_nxt  = poll_r;
    pend_nxt  = pend_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    miss_nxt  = miss_r;
    done_nxt  = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (tick.action inside {[ACT_START:ACT_READ]}) begin
        miss_nxt  = 1'b0;
        count_nxt = '0;
        bit_nxt   = '0;
      end
      case (tick.action)
        ACT_START: begin
          phase_nxt = PH_S0;
          scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1;
        end
        ACT_STOP: begin
          phase_nxt = PH_P0;
          scl_nxt = 1'b0; sda_nxt = 1'b0; drv_nxt = 1'b1;
        end
        ACT_WRITE: begin
          phase_nxt = PH_WLO;
          tx_nxt  = {tick.tx_byte[6:0], 1'b0};
          scl_nxt = 1'b0; sda_nxt = tick.tx_byte[7]; drv_nxt = 1'b1;
        end
        ACT_WACK: begin
          phase_nxt = PH_A0;
          scl_nxt = 1'b0; drv_nxt = 1'b0;
        end
        ACT_READ: begin
          phase_nxt = PH_RLO;
          rx_nxt   = '0;
          pend_nxt = tick.ack_after_read;
          scl_nxt  = 1'b0; drv_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (phase_r == PH_A2) begin
      // poll for acknowledge while scl is high
      if (!tick.sda_sample) begin
        phase_nxt = PH_IDLE;
        scl_nxt   = 1'b0; drv_nxt = 1'b0;
        done_nxt  = 1'b1;
      end else begin
        poll_nxt = poll_inc[7:0];
        if (poll_inc >= {1'b0, cfg.ack_timeout_ticks}) begin
          miss_nxt  = 1'b1;
          count_nxt = '0;
          phase_nxt = PH_P0;
          scl_nxt   = 1'b0; sda_nxt = 1'b0; drv_nxt = 1'b1;
        end
      end
    end else if (hold_half) begin
      count_nxt = count_inc[TIMER_WIDTH-1:0];
    end else begin
      // half period ends: step to the next line setting
      count_nxt = '0;
      case (phase_r)
        PH_S0: begin
          phase_nxt = PH_S1;
          scl_nxt = 1'b1; sda_nxt = 1'b0; drv_nxt = 1'b1;
        end
        PH_S1: begin
          phase_nxt = PH_IDLE;
          scl_nxt = 1'b0; sda_nxt = 1'b0; drv_nxt = 1'b1;
          done_nxt = 1'b1;
        end
        PH_P0: begin
          phase_nxt = PH_P1;
          scl_nxt = 1'b1; sda_nxt = 1'b0; drv_nxt = 1'b1;
        end
        PH_P1: begin
          phase_nxt = PH_IDLE;
          scl_nxt = 1'b1; sda_nxt = 1'b1; drv_nxt = 1'b1;
          done_nxt = 1'b1;
        end
        PH_WLO: begin
          phase_nxt = PH_WHI;
          scl_nxt = 1'b1; drv_nxt = 1'b1;
        end
        PH_WHI: begin
          bit_nxt = bit_inc;
          if (bit_inc < BIT_IDX_W'(BITS_PER_BYTE)) begin
            phase_nxt = PH_WLO;
            tx_nxt  = {tx_r[6:0], 1'b0};
            scl_nxt = 1'b0; sda_nxt = tx_r[7]; drv_nxt = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
            scl_nxt  = 1'b0; drv_nxt = 1'b1;
            done_nxt = 1'b1;
          end
        end
        PH_A0: begin
          phase_nxt = PH_A1;
          scl_nxt = 1'b1; drv_nxt = 1'b0;
        end
        PH_A1: begin
          phase_nxt = PH_A2;
          poll_nxt  = '0;
        end
        PH_RLO: begin
          phase_nxt = PH_RHI;
          scl_nxt = 1'b1; drv_nxt = 1'b0;
        end
        PH_RHI: begin
          rx_nxt  = {rx_r[6:0], tick.sda_sample};
          bit_nxt = bit_inc;
          if (bit_inc < BIT_IDX_W'(BITS_PER_BYTE)) begin
            phase_nxt = PH_RLO;
            scl_nxt = 1'b0; drv_nxt = 1'b0;
          end else begin
            phase_nxt = PH_KLO;
            scl_nxt = 1'b0; sda_nxt = ~pend_r; drv_nxt = 1'b1;
          end
        end
        PH_KLO: begin
          phase_nxt = PH_KHI;
          scl_nxt = 1'b1; drv_nxt = 1'b1;
        end
        PH_KHI: begin
          phase_nxt = PH_IDLE;
          scl_nxt  = 1'b0; drv_nxt = 1'b1;
          done_nxt = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      bit_r   <= '0;
      tx_r    <= '0;
      rx_r    <= '0;
      poll_r  <= '0;
      pend_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      drv_r   <= 1'b1;
      miss_r  <= 1'b0;
      res_r   <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      bit_r   <= bit_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      poll_r  <= poll_nxt;
      pend_r  <= pend_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drv_r   <= drv_nxt;
      miss_r  <= miss_nxt;
      res_r.scl_level   <= scl_nxt;
      res_r.sda_level   <= sda_nxt;
      res_r.sda_drive   <= drv_nxt;
      res_r.busy_res    <= (phase_nxt != PH_IDLE);
      res_r.done_res    <= done_nxt;
      res_r.rx_byte     <= rx_nxt;
      res_r.ack_missing <= miss_nxt;
    end
  end

  assign res = res_r;

  // a completed command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.done_res |-> !res_r.busy_res)
    else $error("done reported while still busy");

  // ack polling only with scl high and sda released
  a_poll_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_A2) |-> (scl_r && !drv_r))
    else $error("ack poll with wrong line drive");

  // half period counter stays below its limit
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE && phase_r != PH_A2 && hp != '0) |-> (count_r < hp))
    else $error("half period counter overran");

  // bit index never passes one byte
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BIT_IDX_W'(BITS_PER_BYTE))
    else $error("bit index out of range");

  // a start always follows with the sda falling edge under high scl
  a_start_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (en && phase_r == PH_S0 && !hold_half) |=> (scl_r && !sda_r && drv_r))
    else $error("start condition not formed");

endmodule

>>> hw/rtl/i2c_master_bit_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit: i2c master line sequencer, one tick per beat
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | in_data  (in_beat_t)
//   out_    | output    | out_valid / out_stall | out_data (out_beat_t)
//   cfg_    | apb slave | psel/penable/pready   | paddr, pwdata, prdata
//
// Each tick beat is registered, then runs through the phase logic into the
// result register, one beat per cycle unless out_stall holds a waiting result.
// The tick register and the result register form a two-deep pipe, so a new
// tick is taken while a result waits; out_stall backs up to in_stall.
// rst_n is synchronous; reset sets core scl, sda high and driven, out_data 0.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit
  import i2cm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_regs_t cfg_r;
  in_beat_t  tick_r;
  logic      tick_vld_r;
  logic      out_vld_r;
  logic      advance;
  logic      in_take;
  logic      reg_sel;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= HALF_PERIOD_RST;
      cfg_r.ack_timeout_ticks <= ACK_TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == REG_HALF_PERIOD) begin
        cfg_r.half_period_ticks <= pwdata[15:0];
      end else begin
        cfg_r.ack_timeout_ticks <= pwdata[7:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_ACK_TIMEOUT) ? {24'd0, cfg_r.ack_timeout_ticks}
                                               : {16'd0, cfg_r.half_period_ticks};

  // pipe control: the tick stage moves when the result slot is free
  assign advance  = tick_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = tick_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_take) begin
        tick_vld_r <= 1'b1;
      end else if (advance) begin
        tick_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // tick register
  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r <= in_data;
    end
  end

  // phase sequencer with result register
  i2cm_seq_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (advance),
    .tick (tick_r),
    .cfg  (cfg_r),
    .res  (out_data)
  );

  assign out_valid = out_vld_r;

endmodule
